### rtl/assert_macros.svh
// Assertion macros for the checker file of the triangle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is high.
`define TCP_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds through reset.
`define TCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tcp_pkg.sv
// Package of constants, tables and types for the triangle cull and project block.
package tcp_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int DIST_WIDTH      = 16;
   localparam logic [DIST_WIDTH-1:0] DIST_RESET = 16'd256;

   localparam int STATUS_WIDTH = 2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_VISIBLE = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_CULLED  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO_Z  = 2'd2;

   localparam int NUM_COORDS = 9;
   localparam int NUM_LANES  = 6;
   localparam int NUM_TERMS  = 6;

   // Coordinate indexes: x0 y0 z0 x1 y1 z1 x2 y2 z2 are 0 to 8.
   // Each determinant term is the product of three coordinates.
   localparam int unsigned TERM_A [NUM_TERMS] = '{0, 0, 1, 1, 2, 2};
   localparam int unsigned TERM_B [NUM_TERMS] = '{4, 5, 3, 5, 3, 4};
   localparam int unsigned TERM_C [NUM_TERMS] = '{8, 7, 8, 6, 7, 6};
   localparam logic [NUM_TERMS-1:0] TERM_NEG = 6'b100110;

   typedef struct packed {
      logic full;
      logic empty;
   } tcp_q_stat_type;

endpackage

### rtl/tcp_if.sv
// Valid and ready channel interfaces for triangles in and projected results out.
interface tcp_req_if #(
   parameter int COORD_WIDTH = tcp_pkg::COORD_WIDTH_DEF
) ();
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] v0_x;
   logic signed [COORD_WIDTH-1:0] v0_y;
   logic signed [COORD_WIDTH-1:0] v0_z;
   logic signed [COORD_WIDTH-1:0] v1_x;
   logic signed [COORD_WIDTH-1:0] v1_y;
   logic signed [COORD_WIDTH-1:0] v1_z;
   logic signed [COORD_WIDTH-1:0] v2_x;
   logic signed [COORD_WIDTH-1:0] v2_y;
   logic signed [COORD_WIDTH-1:0] v2_z;

   modport source (
      output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
      input  ready
   );
   modport sink (
      input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
      output ready
   );
endinterface

interface tcp_rsp_if #(
   parameter int COORD_WIDTH = tcp_pkg::COORD_WIDTH_DEF
) ();
   logic valid;
   logic ready;
   logic [tcp_pkg::STATUS_WIDTH-1:0] status;
   logic signed [COORD_WIDTH-1:0] p0_x;
   logic signed [COORD_WIDTH-1:0] p0_y;
   logic signed [COORD_WIDTH-1:0] p1_x;
   logic signed [COORD_WIDTH-1:0] p1_y;
   logic signed [COORD_WIDTH-1:0] p2_x;
   logic signed [COORD_WIDTH-1:0] p2_y;

   modport source (
      output valid, status, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
      input  ready
   );
   modport sink (
      input  valid, status, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
      output ready
   );
endinterface

### rtl/tcp_front.sv
// Front pipeline: determinant of the three vertices, facing test and depth check.
module tcp_front #(
   parameter int COORD_WIDTH = tcp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [tcp_pkg::NUM_COORDS*COORD_WIDTH-1:0] in_coords,
   input  tcp_pkg::tcp_q_stat_type               q_stat,
   output logic                                  push,
   output logic [tcp_pkg::NUM_COORDS*COORD_WIDTH-1:0] out_coords,
   output logic [tcp_pkg::STATUS_WIDTH-1:0]      out_status
);
   import tcp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W;
   localparam int TW = 3 * W + 1;
   localparam int CW = NUM_COORDS * W;

   logic          en;
   logic [3:0]    vld_ff, vld_in;
   logic [CW-1:0] crd1_ff, crd2_ff, crd3_ff, crd4_ff;
   logic          zero1_ff, zero2_ff, zero3_ff;
   logic          zero1_in;

   logic signed [PW-1:0] ab1_ff [NUM_TERMS];
   logic signed [PW-1:0] ab1_in [NUM_TERMS];
   logic signed [W-1:0]  c1_ff  [NUM_TERMS];
   logic signed [W-1:0]  c1_in  [NUM_TERMS];
   logic signed [PW-1:0] ph2_ff [NUM_TERMS];
   logic signed [PW-1:0] ph2_in [NUM_TERMS];
   logic signed [PW:0]   pl2_ff [NUM_TERMS];
   logic signed [PW:0]   pl2_in [NUM_TERMS];
   logic signed [TW-1:0] trm3_ff [NUM_TERMS];
   logic signed [TW-1:0] trm3_in [NUM_TERMS];
   logic [STATUS_WIDTH-1:0] stat4_ff, stat4_in;

   assign en       = !vld_ff[3] || !q_stat.full;
   assign in_ready = en;
   assign push     = vld_ff[3] && !q_stat.full;
   assign vld_in   = {vld_ff[2:0], in_valid};
   assign out_coords = crd4_ff;
   assign out_status = stat4_ff;

   assign zero1_in = (in_coords[2*W +: W] == '0) || (in_coords[5*W +: W] == '0) ||
                     (in_coords[8*W +: W] == '0);

   always_comb begin
      logic signed [W-1:0]  fa, fb;
      logic signed [W-1:0]  hi;
      logic signed [W:0]    lo;
      logic signed [TW-1:0] sum;
      logic signed [TW-1:0] tot;
      for (int t = 0; t < NUM_TERMS; t++) begin
         fa = $signed(in_coords[TERM_A[t]*W +: W]);
         fb = $signed(in_coords[TERM_B[t]*W +: W]);
         ab1_in[t] = PW'(fa) * PW'(fb);
         c1_in[t]  = $signed(in_coords[TERM_C[t]*W +: W]);
         hi = $signed(ab1_ff[t][PW-1:W]);
         lo = $signed({1'b0, ab1_ff[t][W-1:0]});
         ph2_in[t] = PW'(hi) * PW'(c1_ff[t]);
         pl2_in[t] = (PW+1)'(lo) * (PW+1)'(c1_ff[t]);
         sum = (TW'(ph2_ff[t]) <<< W) + TW'(pl2_ff[t]);
         trm3_in[t] = TERM_NEG[t] ? -sum : sum;
      end
      tot = '0;
      for (int t = 0; t < NUM_TERMS; t++) begin
         tot = tot + trm3_ff[t];
      end
      if (!tot[TW-1] && (tot != '0)) begin
         stat4_in = STATUS_CULLED;
      end else if (zero3_ff) begin
         stat4_in = STATUS_ZERO_Z;
      end else begin
         stat4_in = STATUS_VISIBLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crd1_ff  <= in_coords;
         crd2_ff  <= crd1_ff;
         crd3_ff  <= crd2_ff;
         crd4_ff  <= crd3_ff;
         zero1_ff <= zero1_in;
         zero2_ff <= zero1_ff;
         zero3_ff <= zero2_ff;
         stat4_ff <= stat4_in;
         for (int t = 0; t < NUM_TERMS; t++) begin
            ab1_ff[t]  <= ab1_in[t];
            c1_ff[t]   <= c1_in[t];
            ph2_ff[t]  <= ph2_in[t];
            pl2_ff[t]  <= pl2_in[t];
            trm3_ff[t] <= trm3_in[t];
         end
      end
   end
endmodule

### rtl/tcp_queue.sv
// Short queue that decouples the facing test from the projection pipeline.
module tcp_queue #(
   parameter int ENTRY_WIDTH = 8,
   parameter int DEPTH       = tcp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [ENTRY_WIDTH-1:0] wr_data,
   input  logic                   pop,
   output logic [ENTRY_WIDTH-1:0] rd_data,
   output tcp_pkg::tcp_q_stat_type q_stat
);
   import tcp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [ENTRY_WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == NW'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + NW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

### rtl/tcp_back.sv
// Back pipeline: scaling by the plane distance, radix-2 division by depth and saturation.
module tcp_back #(
   parameter int COORD_WIDTH = tcp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [tcp_pkg::DIST_WIDTH-1:0]         proj_dist,
   input  tcp_pkg::tcp_q_stat_type                q_stat,
   input  logic [tcp_pkg::NUM_COORDS*COORD_WIDTH+tcp_pkg::STATUS_WIDTH-1:0] q_data,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tcp_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic [tcp_pkg::NUM_LANES*COORD_WIDTH-1:0] rsp_coords
);
   import tcp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int NW = W + DIST_WIDTH - 1;
   localparam int NS = NW;
   localparam int CW = NUM_COORDS * W;
   localparam logic [NW-1:0] POS_LIM = NW'((64'(1) << (W - 1)) - 64'(1));
   localparam logic [NW-1:0] NEG_LIM = NW'(64'(1) << (W - 1));

   logic          en;
   logic [NS:0]   vld_ff, vld_in;
   logic [STATUS_WIDTH-1:0] stat_ff [NS+1];
   logic [NW-1:0] nq_ff  [NUM_LANES][NS+1];
   logic [NW-1:0] nq_in  [NUM_LANES][NS+1];
   logic [W-1:0]  rem_ff [NUM_LANES][NS+1];
   logic [W-1:0]  rem_in [NUM_LANES][NS+1];
   logic [W-1:0]  dz_ff  [NUM_LANES][NS+1];
   logic [W-1:0]  dz_in  [NUM_LANES];
   logic          neg_ff [NUM_LANES][NS+1];
   logic          neg_in [NUM_LANES];
   logic [W-1:0]  sat    [NUM_LANES];

   logic                          rsp_vld_ff;
   logic [STATUS_WIDTH-1:0]       rsp_stat_ff;
   logic [NUM_LANES*W-1:0]        rsp_crd_ff, rsp_crd_in;

   assign en     = !rsp_vld_ff || rsp_ready;
   assign pop    = en && !q_stat.empty;
   assign vld_in = {vld_ff[NS-1:0], !q_stat.empty};

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_coords = rsp_crd_ff;

   always_comb begin
      logic [W-1:0]  c, z, cm;
      logic [W:0]    trial, diff;
      logic          ge;
      logic [NW-1:0] q;
      for (int l = 0; l < NUM_LANES; l++) begin
         c  = q_data[(3*(l/2) + (l%2))*W +: W];
         z  = q_data[(3*(l/2) + 2)*W +: W];
         cm = c[W-1] ? (~c + W'(1)) : c;
         dz_in[l]     = z[W-1] ? (~z + W'(1)) : z;
         neg_in[l]    = c[W-1] ^ z[W-1];
         nq_in[l][0]  = NW'(cm) * NW'(proj_dist);
         rem_in[l][0] = '0;
         for (int s = 0; s < NS; s++) begin
            trial = {rem_ff[l][s], nq_ff[l][s][NW-1]};
            ge    = (trial >= {1'b0, dz_ff[l][s]});
            diff  = trial - {1'b0, dz_ff[l][s]};
            rem_in[l][s+1] = ge ? diff[W-1:0] : trial[W-1:0];
            nq_in[l][s+1]  = {nq_ff[l][s][NW-2:0], ge};
         end
         q = nq_ff[l][NS];
         if (!neg_ff[l][NS]) begin
            sat[l] = (q > POS_LIM) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
         end else begin
            sat[l] = (q > NEG_LIM) ? {1'b1, {(W-1){1'b0}}} : W'(~q + NW'(1));
         end
         rsp_crd_in[l*W +: W] = (stat_ff[NS] == STATUS_VISIBLE) ? sat[l] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stat_ff[0] <= q_data[CW +: STATUS_WIDTH];
         for (int s = 0; s < NS; s++) begin
            stat_ff[s+1] <= stat_ff[s];
         end
         for (int l = 0; l < NUM_LANES; l++) begin
            nq_ff[l][0]  <= nq_in[l][0];
            rem_ff[l][0] <= rem_in[l][0];
            dz_ff[l][0]  <= dz_in[l];
            neg_ff[l][0] <= neg_in[l];
            for (int s = 0; s < NS; s++) begin
               nq_ff[l][s+1]  <= nq_in[l][s+1];
               rem_ff[l][s+1] <= rem_in[l][s+1];
               dz_ff[l][s+1]  <= dz_ff[l][s];
               neg_ff[l][s+1] <= neg_ff[l][s];
            end
         end
         rsp_stat_ff <= stat_ff[NS];
         rsp_crd_ff  <= rsp_crd_in;
      end
   end
endmodule

### rtl/triangle_cull_and_project.sv
// Top level of the triangle back-face cull and perspective projection block.
//
//   channel   direction  handshake      contents
//   req_chan  in         valid/ready    three vertices, nine signed coordinates
//   rsp_chan  out        valid/ready    status and six projected coordinates
//   csr_*     in         write enable   projection plane distance
//
// One triangle transaction is taken every cycle while the result side keeps up.
// Each result passes through the front pipeline, the queue and the radix-2
// divider, which retires one quotient bit per stage over COORD_WIDTH + 15 stages.
// Synchronous reset empties both pipelines and the queue and sets the distance to 256.
// A stalled result holds the back pipeline; the front runs on until the queue is full.
module triangle_cull_and_project #(
   parameter int COORD_WIDTH = tcp_pkg::COORD_WIDTH_DEF,
   parameter int QUEUE_DEPTH = tcp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   tcp_req_if.sink                        req_chan,
   tcp_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [tcp_pkg::DIST_WIDTH-1:0] csr_wr_data
);
   import tcp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int CW = NUM_COORDS * W;
   localparam int EW = CW + STATUS_WIDTH;

   logic [DIST_WIDTH-1:0]   dist_ff;
   logic [CW-1:0]           in_coords, f_coords;
   logic [STATUS_WIDTH-1:0] f_status;
   logic                    push, pop;
   logic [EW-1:0]           q_data;
   tcp_q_stat_type          q_stat;
   logic [NUM_LANES*W-1:0]  out_coords;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET;
      end else if (csr_wr_en) begin
         dist_ff <= csr_wr_data;
      end
   end

   assign in_coords = {req_chan.v2_z, req_chan.v2_y, req_chan.v2_x,
                       req_chan.v1_z, req_chan.v1_y, req_chan.v1_x,
                       req_chan.v0_z, req_chan.v0_y, req_chan.v0_x};

   tcp_front #(.COORD_WIDTH(W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_coords  (in_coords),
      .q_stat     (q_stat),
      .push       (push),
      .out_coords (f_coords),
      .out_status (f_status)
   );

   tcp_queue #(.ENTRY_WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data ({f_status, f_coords}),
      .pop     (pop),
      .rd_data (q_data),
      .q_stat  (q_stat)
   );

   tcp_back #(.COORD_WIDTH(W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .proj_dist  (dist_ff),
      .q_stat     (q_stat),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_status (rsp_chan.status),
      .rsp_coords (out_coords)
   );

   assign rsp_chan.p0_x = out_coords[0*W +: W];
   assign rsp_chan.p0_y = out_coords[1*W +: W];
   assign rsp_chan.p1_x = out_coords[2*W +: W];
   assign rsp_chan.p1_y = out_coords[3*W +: W];
   assign rsp_chan.p2_x = out_coords[4*W +: W];
   assign rsp_chan.p2_y = out_coords[5*W +: W];
endmodule

### rtl/tcp_checker.sv
// Port checker for the triangle block and its binding to the top level.
`include "assert_macros.svh"

module tcp_checker #(
   parameter int COORD_WIDTH = tcp_pkg::COORD_WIDTH_DEF
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [tcp_pkg::STATUS_WIDTH-1:0]      rsp_status,
   input logic [tcp_pkg::NUM_LANES*COORD_WIDTH-1:0] rsp_coords
);
   import tcp_pkg::*;

   `TCP_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")
   `TCP_ASSERT_CLK(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "stalled result dropped")
   `TCP_ASSERT_CLK(a_rsp_payload_holds, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_coords) && $stable(rsp_status), "stalled result changed")
   `TCP_ASSERT_CLK(a_rsp_unprojected_zero, clock, reset, rsp_valid && (rsp_status != STATUS_VISIBLE) |-> (rsp_coords == '0), "coordinates not zero on an unprojected face")
endmodule

bind triangle_cull_and_project tcp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tcp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_coords ({rsp_chan.p2_y, rsp_chan.p2_x, rsp_chan.p1_y,
                 rsp_chan.p1_x, rsp_chan.p0_y, rsp_chan.p0_x})
);
